// File: src/tcc_pkg.sv
// Package for the turn curvature check: widths, constants and shared types.
`default_nettype none
package tcc_pkg;

   localparam int COORD_WIDTH  = 32;
   localparam int FRAC_BITS    = 16;
   localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
   localparam int NORM_BITS    = 30;
   localparam int SNORM_WIDTH  = NORM_BITS + 1;
   localparam int PROD_WIDTH   = 2 * SNORM_WIDTH;
   localparam int SUM_WIDTH    = PROD_WIDTH + 1;
   localparam int LEN_WIDTH    = 32;
   localparam int LMIN3_WIDTH  = LEN_WIDTH + 2;
   localparam int CURV_WIDTH   = 32;
   localparam int RAD_WIDTH    = 64;
   localparam int ROOT_WIDTH   = RAD_WIDTH / 2;
   localparam int SQRT_STAGES  = ROOT_WIDTH;
   localparam int DIV_WIDTH    = 64;
   localparam int DIV_STAGES   = DIV_WIDTH;
   localparam int C2_SHIFT     = 62;
   localparam int W_SHIFT      = 34 + 2 * FRAC_BITS;
   localparam int TAN_WIDTH    = 23;

   localparam logic [TAN_WIDTH-1:0]  TAN_MILLI_Q32  = TAN_WIDTH'(4294969);
   localparam logic [CURV_WIDTH-1:0] MAX_CURV_RESET = CURV_WIDTH'(65536);

   typedef struct packed {
      logic [DIV_WIDTH-1:0] q;
      logic                 sat;
   } div_out_type;

   typedef struct packed {
      logic [NORM_BITS-1:0] p;
      logic [NORM_BITS-1:0] q;
   } norm_pair_type;

   typedef struct packed {
      logic                     valid;
      logic                     straight;
      logic                     dneg;
      logic                     lmin0;
      logic [LMIN3_WIDTH-1:0]   lmin3;
      logic [NORM_BITS-1:0]     dm;
      logic [2*NORM_BITS-1:0]   xm2;
   } front_side_type;

   typedef struct packed {
      logic                     valid;
      logic                     straight;
      logic                     dneg;
      logic                     lmin0;
      logic                     s2zero;
      logic [LMIN3_WIDTH-1:0]   lmin3;
      logic [DIV_WIDTH-1:0]     s2;
   } back_side_type;

endpackage
`default_nettype wire

// File: src/tcc_if.sv
// Channel interfaces for the turn curvature check: request and response.
`default_nettype none
interface tcc_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [tcc_pkg::COORD_WIDTH-1:0]  a_x;
   logic signed [tcc_pkg::COORD_WIDTH-1:0]  a_y;
   logic signed [tcc_pkg::COORD_WIDTH-1:0]  b_x;
   logic signed [tcc_pkg::COORD_WIDTH-1:0]  b_y;
   logic signed [tcc_pkg::COORD_WIDTH-1:0]  c_x;
   logic signed [tcc_pkg::COORD_WIDTH-1:0]  c_y;
   logic        [tcc_pkg::LEN_WIDTH-1:0]    len_ab;
   logic        [tcc_pkg::LEN_WIDTH-1:0]    len_bc;

   modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, len_ab, len_bc,
                   input ready);
   modport sink   (input valid, a_x, a_y, b_x, b_y, c_x, c_y, len_ab, len_bc,
                   output ready);
endinterface

interface tcc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [tcc_pkg::CURV_WIDTH-1:0]     curv_value;
   logic                               near_straight;
   logic                               feasible;

   modport source (output valid, curv_value, near_straight, feasible, input ready);
   modport sink   (input valid, curv_value, near_straight, feasible, output ready);
endinterface
`default_nettype wire

// File: src/turn_curvature_check.sv
// Top level of the turn curvature check pipeline.
//
// A request transaction carries points A, B, C and the lengths of AB and BC.
// Each accepted transaction yields exactly one response transaction with the
// curvature magnitude (Q16.16, all ones when saturated), a near-straight flag
// and a feasible flag against max_curvature. csr_wr_en writes max_curvature
// from csr_wr_data; write it only while no transaction is in flight.
// Throughput is one transaction per cycle while the receiver does not stall.
// From acceptance to rsp valid a transaction passes seven front stages
// (differences, vector scaling, products, sums, pair scaling, angle test
// and squares, radicand), a 32-stage square root for the vector length,
// two stages to form the divisors, two parallel 64-stage dividers for the
// half-angle cosine and sine terms, one select stage, a 32-stage square
// root for the cosine, a 64-stage divider for the angle term, a 64-stage
// divider by three times the shorter length and the response register.
// Reset empties the pipeline and loads max_curvature with 1.0.
// When the receiver stalls the whole pipeline holds and req ready drops, so
// nothing is lost or repeated; bubbles do not collapse under a stall.
`default_nettype none
module turn_curvature_check (
   input  wire logic                             clock,
   input  wire logic                             reset,
   tcc_req_if.sink                               req_ch,
   tcc_rsp_if.source                             rsp_ch,
   input  wire logic                             csr_wr_en,
   input  wire logic [tcc_pkg::CURV_WIDTH-1:0]   csr_wr_data
);
   import tcc_pkg::*;

   function automatic norm_pair_type shrink(input logic [63:0] mp, input logic [63:0] mq);
      logic [63:0]   both;
      logic [6:0]    len;
      logic [6:0]    sh;
      norm_pair_type r;
      both = mp | mq;
      len  = '0;
      for (int i = 0; i < 64; i++) begin
         if (both[i]) len = 7'(i + 1);
      end
      sh  = (len > 7'(NORM_BITS)) ? len - 7'(NORM_BITS) : 7'd0;
      r.p = NORM_BITS'(mp >> sh);
      r.q = NORM_BITS'(mq >> sh);
      return r;
   endfunction

   function automatic logic [DIFF_WIDTH-1:0] mag_diff(input logic signed [DIFF_WIDTH-1:0] v);
      return v[DIFF_WIDTH-1] ? DIFF_WIDTH'(-v) : DIFF_WIDTH'(v);
   endfunction

   function automatic logic signed [SNORM_WIDTH-1:0] signed_of(input logic neg,
                                                              input logic [NORM_BITS-1:0] m);
      logic signed [SNORM_WIDTH-1:0] s;
      s = $signed({1'b0, m});
      return neg ? -s : s;
   endfunction

   logic en;
   logic [CURV_WIDTH-1:0] max_curv_ff;

   // stage 1
   logic                          v1_ff;
   logic signed [DIFF_WIDTH-1:0]  ux1_ff, uy1_ff, vx1_ff, vy1_ff;
   logic signed [DIFF_WIDTH-1:0]  ux1_in, uy1_in, vx1_in, vy1_in;
   logic [LEN_WIDTH-1:0]          lmin1_ff, lmin1_in;
   // stage 2
   front_side_type                fs2_ff, fs2_in;
   logic signed [SNORM_WIDTH-1:0] ux2_ff, uy2_ff, vx2_ff, vy2_ff;
   logic signed [SNORM_WIDTH-1:0] ux2_in, uy2_in, vx2_in, vy2_in;
   norm_pair_type                 u_norm, v_norm;
   // stage 3
   front_side_type                fs3_ff;
   logic signed [PROD_WIDTH-1:0]  pxx3_ff, pyy3_ff, pxy3_ff, pyx3_ff;
   // stage 4
   front_side_type                fs4_ff;
   logic signed [SUM_WIDTH-1:0]   dot4_ff, crs4_ff;
   // stage 5
   front_side_type                fs5_ff, fs5_in;
   logic [NORM_BITS-1:0]          xm5_ff;
   norm_pair_type                 dx_norm;
   // stage 6
   front_side_type                fs6_ff, fs6_in;
   logic [2*NORM_BITS-1:0]        dm2_6_ff;
   logic [61:0]                   tan_prod;
   // stage 7
   front_side_type                fs7_ff;
   logic [RAD_WIDTH-1:0]          rad7_ff;
   // first square root
   front_side_type                line_a_ff [SQRT_STAGES];
   front_side_type                fsa;
   logic [ROOT_WIDTH-1:0]         root_a;
   // stages 8 and 8b
   front_side_type                fs8_ff;
   logic [ROOT_WIDTH-1:0]         r8_ff, rdm8_ff;
   back_side_type                 bs8b_ff, bs8b_in;
   logic [DIV_WIDTH-1:0]          num_a8b_ff, den_a8b_ff, num_b8b_ff, den_b8b_ff;
   logic [DIV_WIDTH-1:0]          prod8;
   logic [2*DIV_WIDTH-1:0]        wide_a, wide_b;
   // first dividers
   back_side_type                 line_b_ff [DIV_STAGES];
   back_side_type                 bsb;
   div_out_type                   res_a, res_b;
   logic [DIV_WIDTH-1:0]          qa, qb;
   // stage 9
   back_side_type                 bs9_ff, bs9_in;
   logic [RAD_WIDTH-1:0]          c2_9_ff, c2_9_in;
   // second square root
   back_side_type                 line_c_ff [SQRT_STAGES];
   back_side_type                 bsc;
   logic [ROOT_WIDTH-1:0]         root_c;
   logic [2*DIV_WIDTH-1:0]        wide_w;
   // angle divider
   back_side_type                 line_d_ff [DIV_STAGES];
   back_side_type                 bsd;
   div_out_type                   res_w;
   logic [DIV_WIDTH-1:0]          w_val;
   // length divider
   back_side_type                 line_e_ff [DIV_STAGES];
   back_side_type                 bse;
   div_out_type                   res_k;
   logic                          k_sat;
   logic [CURV_WIDTH-1:0]         k_val;
   // response register
   logic                          rsp_valid_ff;
   logic [CURV_WIDTH-1:0]         curv_ff;
   logic                          near_ff, feas_ff;

   assign en           = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_curv_ff <= MAX_CURV_RESET;
      end else if (csr_wr_en) begin
         max_curv_ff <= csr_wr_data;
      end
   end

   always_comb begin
      ux1_in   = DIFF_WIDTH'(req_ch.b_x) - DIFF_WIDTH'(req_ch.a_x);
      uy1_in   = DIFF_WIDTH'(req_ch.b_y) - DIFF_WIDTH'(req_ch.a_y);
      vx1_in   = DIFF_WIDTH'(req_ch.b_x) - DIFF_WIDTH'(req_ch.c_x);
      vy1_in   = DIFF_WIDTH'(req_ch.b_y) - DIFF_WIDTH'(req_ch.c_y);
      lmin1_in = (req_ch.len_ab < req_ch.len_bc) ? req_ch.len_ab : req_ch.len_bc;
   end

   always_comb begin
      u_norm = shrink(64'(mag_diff(ux1_ff)), 64'(mag_diff(uy1_ff)));
      v_norm = shrink(64'(mag_diff(vx1_ff)), 64'(mag_diff(vy1_ff)));
      ux2_in = signed_of(ux1_ff[DIFF_WIDTH-1], u_norm.p);
      uy2_in = signed_of(uy1_ff[DIFF_WIDTH-1], u_norm.q);
      vx2_in = signed_of(vx1_ff[DIFF_WIDTH-1], v_norm.p);
      vy2_in = signed_of(vy1_ff[DIFF_WIDTH-1], v_norm.q);
      fs2_in          = '0;
      fs2_in.valid    = v1_ff;
      fs2_in.lmin0    = (lmin1_ff == '0);
      fs2_in.lmin3    = LMIN3_WIDTH'(lmin1_ff) * LMIN3_WIDTH'(3);
   end

   always_comb begin
      dx_norm = shrink(64'(dot4_ff[SUM_WIDTH-1] ? -dot4_ff : dot4_ff),
                       64'(crs4_ff[SUM_WIDTH-1] ? -crs4_ff : crs4_ff));
      fs5_in      = fs4_ff;
      fs5_in.dm   = dx_norm.p;
      fs5_in.dneg = dot4_ff[SUM_WIDTH-1] && (dx_norm.p != '0);
   end

   always_comb begin
      tan_prod        = 62'(TAN_MILLI_Q32) * 62'(fs5_ff.dm);
      fs6_in          = fs5_ff;
      fs6_in.straight = ((fs5_ff.dm == '0) && (xm5_ff == '0)) ||
                        (!fs5_ff.dneg && (fs5_ff.dm != '0) && ({xm5_ff, 32'd0} < tan_prod));
      fs6_in.xm2      = (2*NORM_BITS)'(xm5_ff) * (2*NORM_BITS)'(xm5_ff);
   end

   assign fsa = line_a_ff[SQRT_STAGES-1];

   always_comb begin
      prod8            = {32'd0, r8_ff} * {32'd0, rdm8_ff};
      bs8b_in          = '0;
      bs8b_in.valid    = fs8_ff.valid;
      bs8b_in.straight = fs8_ff.straight;
      bs8b_in.dneg     = fs8_ff.dneg;
      bs8b_in.lmin0    = fs8_ff.lmin0;
      bs8b_in.lmin3    = fs8_ff.lmin3;
   end

   assign wide_a = (2*DIV_WIDTH)'(num_a8b_ff) << C2_SHIFT;
   assign wide_b = (2*DIV_WIDTH)'(num_b8b_ff) << C2_SHIFT;

   tcc_div u_div_a (
      .clock   (clock),
      .en      (en),
      .div_hi  (wide_a[2*DIV_WIDTH-1:DIV_WIDTH]),
      .div_lo  (wide_a[DIV_WIDTH-1:0]),
      .divisor (den_a8b_ff),
      .result  (res_a)
   );

   tcc_div u_div_b (
      .clock   (clock),
      .en      (en),
      .div_hi  (wide_b[2*DIV_WIDTH-1:DIV_WIDTH]),
      .div_lo  (wide_b[DIV_WIDTH-1:0]),
      .divisor (den_b8b_ff),
      .result  (res_b)
   );

   assign bsb = line_b_ff[DIV_STAGES-1];

   always_comb begin
      qa        = res_a.sat ? '1 : res_a.q;
      qb        = res_b.sat ? '1 : res_b.q;
      bs9_in    = bsb;
      c2_9_in   = bsb.dneg ? qb : qa;
      bs9_in.s2 = bsb.dneg ? qa : qb;
      bs9_in.s2zero = (bs9_in.s2 == '0);
   end

   tcc_isqrt u_sqrt_a (
      .clock    (clock),
      .en       (en),
      .radicand (rad7_ff),
      .root     (root_a)
   );

   tcc_isqrt u_sqrt_c (
      .clock    (clock),
      .en       (en),
      .radicand (c2_9_ff),
      .root     (root_c)
   );

   assign bsc    = line_c_ff[SQRT_STAGES-1];
   assign wide_w = (2*DIV_WIDTH)'(root_c) << W_SHIFT;

   tcc_div u_div_w (
      .clock   (clock),
      .en      (en),
      .div_hi  (wide_w[2*DIV_WIDTH-1:DIV_WIDTH]),
      .div_lo  (wide_w[DIV_WIDTH-1:0]),
      .divisor (bsc.s2),
      .result  (res_w)
   );

   assign bsd   = line_d_ff[DIV_STAGES-1];
   assign w_val = res_w.sat ? '1 : res_w.q;

   tcc_div u_div_k (
      .clock   (clock),
      .en      (en),
      .div_hi  ('0),
      .div_lo  (w_val),
      .divisor (DIV_WIDTH'(bsd.lmin3)),
      .result  (res_k)
   );

   assign bse = line_e_ff[DIV_STAGES-1];

   always_comb begin
      k_sat = bse.straight || bse.lmin0 || bse.s2zero || res_k.sat ||
              (res_k.q[DIV_WIDTH-1:CURV_WIDTH] != '0);
      k_val = k_sat ? '1 : res_k.q[CURV_WIDTH-1:0];
   end

   // advance the pipeline as one unit; hold everything on a stall
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         fs2_ff.valid <= 1'b0;
         fs3_ff.valid <= 1'b0;
         fs4_ff.valid <= 1'b0;
         fs5_ff.valid <= 1'b0;
         fs6_ff.valid <= 1'b0;
         fs7_ff.valid <= 1'b0;
         fs8_ff.valid <= 1'b0;
         bs8b_ff.valid <= 1'b0;
         bs9_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SQRT_STAGES; i++) begin
            line_a_ff[i].valid <= 1'b0;
            line_c_ff[i].valid <= 1'b0;
         end
         for (int i = 0; i < DIV_STAGES; i++) begin
            line_b_ff[i].valid <= 1'b0;
            line_d_ff[i].valid <= 1'b0;
            line_e_ff[i].valid <= 1'b0;
         end
      end else if (en) begin
         v1_ff    <= req_ch.valid;
         ux1_ff   <= ux1_in;
         uy1_ff   <= uy1_in;
         vx1_ff   <= vx1_in;
         vy1_ff   <= vy1_in;
         lmin1_ff <= lmin1_in;

         fs2_ff <= fs2_in;
         ux2_ff <= ux2_in;
         uy2_ff <= uy2_in;
         vx2_ff <= vx2_in;
         vy2_ff <= vy2_in;

         fs3_ff  <= fs2_ff;
         pxx3_ff <= ux2_ff * vx2_ff;
         pyy3_ff <= uy2_ff * vy2_ff;
         pxy3_ff <= ux2_ff * vy2_ff;
         pyx3_ff <= uy2_ff * vx2_ff;

         fs4_ff  <= fs3_ff;
         dot4_ff <= SUM_WIDTH'(pxx3_ff) + SUM_WIDTH'(pyy3_ff);
         crs4_ff <= SUM_WIDTH'(pxy3_ff) - SUM_WIDTH'(pyx3_ff);

         fs5_ff <= fs5_in;
         xm5_ff <= dx_norm.q;

         fs6_ff   <= fs6_in;
         dm2_6_ff <= (2*NORM_BITS)'(fs5_ff.dm) * (2*NORM_BITS)'(fs5_ff.dm);

         fs7_ff  <= fs6_ff;
         rad7_ff <= RAD_WIDTH'(dm2_6_ff) + RAD_WIDTH'(fs6_ff.xm2);

         line_a_ff[0] <= fs7_ff;
         for (int i = 1; i < SQRT_STAGES; i++) line_a_ff[i] <= line_a_ff[i-1];

         fs8_ff  <= fsa;
         r8_ff   <= root_a;
         rdm8_ff <= root_a + ROOT_WIDTH'(fsa.dm);

         bs8b_ff    <= bs8b_in;
         num_a8b_ff <= DIV_WIDTH'(rdm8_ff);
         den_a8b_ff <= DIV_WIDTH'(r8_ff) << 1;
         num_b8b_ff <= DIV_WIDTH'(fs8_ff.xm2);
         den_b8b_ff <= prod8 << 1;

         line_b_ff[0] <= bs8b_ff;
         for (int i = 1; i < DIV_STAGES; i++) line_b_ff[i] <= line_b_ff[i-1];

         bs9_ff  <= bs9_in;
         c2_9_ff <= c2_9_in;

         line_c_ff[0] <= bs9_ff;
         for (int i = 1; i < SQRT_STAGES; i++) line_c_ff[i] <= line_c_ff[i-1];

         line_d_ff[0] <= bsc;
         for (int i = 1; i < DIV_STAGES; i++) line_d_ff[i] <= line_d_ff[i-1];

         line_e_ff[0] <= bsd;
         for (int i = 1; i < DIV_STAGES; i++) line_e_ff[i] <= line_e_ff[i-1];

         rsp_valid_ff <= bse.valid;
         curv_ff      <= k_val;
         near_ff      <= bse.straight;
         feas_ff      <= (k_val < max_curv_ff);
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.curv_value    = curv_ff;
   assign rsp_ch.near_straight = near_ff;
   assign rsp_ch.feasible      = feas_ff;

   a_straight_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && near_ff) |-> (curv_ff == '1 && !feas_ff))
      else $error("near-straight transaction without saturated curvature");

   a_feasible_below: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && feas_ff) |-> (curv_ff < max_curv_ff))
      else $error("feasible flag set with curvature at or above limit");

   a_zero_len_sat: assert property (@(posedge clock) disable iff (reset)
      (en && bse.valid && bse.lmin0) |=> (rsp_valid_ff && curv_ff == '1 && !feas_ff))
      else $error("zero shorter length did not saturate curvature");

endmodule
`default_nettype wire

// File: src/tcc_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module tcc_isqrt (
   input  wire logic                            clock,
   input  wire logic                            en,
   input  wire logic [tcc_pkg::RAD_WIDTH-1:0]   radicand,
   output logic      [tcc_pkg::ROOT_WIDTH-1:0]  root
);
   import tcc_pkg::*;

   logic [RAD_WIDTH-1:0] n_ff    [SQRT_STAGES];
   logic [RAD_WIDTH-1:0] res_ff  [SQRT_STAGES];
   logic [RAD_WIDTH-1:0] n_in    [SQRT_STAGES];
   logic [RAD_WIDTH-1:0] res_in  [SQRT_STAGES];
   logic [RAD_WIDTH-1:0] src_n   [SQRT_STAGES];
   logic [RAD_WIDTH-1:0] src_res [SQRT_STAGES];
   logic [RAD_WIDTH-1:0] trial   [SQRT_STAGES];

   always_comb begin
      src_n[0]   = radicand;
      src_res[0] = '0;
      for (int i = 1; i < SQRT_STAGES; i++) begin
         src_n[i]   = n_ff[i-1];
         src_res[i] = res_ff[i-1];
      end
      for (int i = 0; i < SQRT_STAGES; i++) begin
         trial[i] = src_res[i] + (RAD_WIDTH'(1) << (RAD_WIDTH - 2 - 2 * i));
         if (src_n[i] >= trial[i]) begin
            n_in[i]   = src_n[i] - trial[i];
            res_in[i] = (src_res[i] >> 1) + (RAD_WIDTH'(1) << (RAD_WIDTH - 2 - 2 * i));
         end else begin
            n_in[i]   = src_n[i];
            res_in[i] = src_res[i] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < SQRT_STAGES; i++) begin
            n_ff[i]   <= n_in[i];
            res_ff[i] <= res_in[i];
         end
      end
   end

   assign root = res_ff[SQRT_STAGES-1][ROOT_WIDTH-1:0];

endmodule
`default_nettype wire

// File: src/tcc_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating.
`default_nettype none
module tcc_div (
   input  wire logic                           clock,
   input  wire logic                           en,
   input  wire logic [tcc_pkg::DIV_WIDTH-1:0]  div_hi,
   input  wire logic [tcc_pkg::DIV_WIDTH-1:0]  div_lo,
   input  wire logic [tcc_pkg::DIV_WIDTH-1:0]  divisor,
   output tcc_pkg::div_out_type                result
);
   import tcc_pkg::*;

   logic [DIV_WIDTH-1:0] rem_ff  [DIV_STAGES];
   logic [DIV_WIDTH-1:0] nq_ff   [DIV_STAGES];
   logic [DIV_WIDTH-1:0] den_ff  [DIV_STAGES];
   logic                 sat_ff  [DIV_STAGES];
   logic [DIV_WIDTH-1:0] rem_in  [DIV_STAGES];
   logic [DIV_WIDTH-1:0] nq_in   [DIV_STAGES];
   logic [DIV_WIDTH-1:0] src_rem [DIV_STAGES];
   logic [DIV_WIDTH-1:0] src_nq  [DIV_STAGES];
   logic [DIV_WIDTH-1:0] src_den [DIV_STAGES];
   logic                 src_sat [DIV_STAGES];
   logic [DIV_WIDTH:0]   part    [DIV_STAGES];
   logic                 ge      [DIV_STAGES];

   always_comb begin
      src_rem[0] = div_hi;
      src_nq[0]  = div_lo;
      src_den[0] = divisor;
      src_sat[0] = (divisor == '0) || divisor[DIV_WIDTH-1] || (div_hi >= divisor);
      for (int i = 1; i < DIV_STAGES; i++) begin
         src_rem[i] = rem_ff[i-1];
         src_nq[i]  = nq_ff[i-1];
         src_den[i] = den_ff[i-1];
         src_sat[i] = sat_ff[i-1];
      end
      for (int i = 0; i < DIV_STAGES; i++) begin
         part[i] = {src_rem[i], src_nq[i][DIV_WIDTH-1]};
         ge[i]   = part[i] >= {1'b0, src_den[i]};
         if (ge[i]) begin
            rem_in[i] = DIV_WIDTH'(part[i] - {1'b0, src_den[i]});
         end else begin
            rem_in[i] = part[i][DIV_WIDTH-1:0];
         end
         nq_in[i] = {src_nq[i][DIV_WIDTH-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < DIV_STAGES; i++) begin
            rem_ff[i] <= rem_in[i];
            nq_ff[i]  <= nq_in[i];
            den_ff[i] <= src_den[i];
            sat_ff[i] <= src_sat[i];
         end
      end
   end

   assign result.q   = nq_ff[DIV_STAGES-1];
   assign result.sat = sat_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

// File: tb/tcc_checker.sv
// Checker for the turn curvature check: predicts each response and compares it.
`timescale 1ns / 100ps
`default_nettype none
module tcc_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   tcc_req_if                                   req_mon,
   tcc_rsp_if                                   rsp_mon,
   input  wire logic                            csr_wr_en,
   input  wire logic [tcc_pkg::CURV_WIDTH-1:0]  csr_wr_data,
   output int unsigned                          fail_count,
   output int unsigned                          pending,
   output int unsigned                          checked
);
   import tcc_pkg::*;

   typedef struct {
      logic [CURV_WIDTH-1:0] curv_value;
      logic                  near_straight;
      logic                  feasible;
   } turn_result_type;

   localparam longint unsigned NORM_LIMIT = 64'd1 << NORM_BITS;
   localparam longint unsigned U64_MAX    = '1;

   turn_result_type       curv_queue[$];
   logic [CURV_WIDTH-1:0] curv_limit;

   function automatic longint unsigned mag(longint v);
      return v < 0 ? 64'd0 - longint'(v) : longint'(v);
   endfunction

   function automatic void shrink(ref longint p, ref longint q);
      longint unsigned mp, mq;
      logic np, nq;
      mp = mag(p);
      mq = mag(q);
      np = p < 0;
      nq = q < 0;
      while ((mp | mq) >= NORM_LIMIT) begin
         mp = mp >> 1;
         mq = mq >> 1;
      end
      p = np ? -longint'(mp) : longint'(mp);
      q = nq ? -longint'(mq) : longint'(mq);
   endfunction

   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint unsigned quot_shift(longint unsigned num, int sh,
                                                  longint unsigned den);
      longint unsigned q, rem;
      logic b;
      q = 0;
      rem = 0;
      if (den == 0 || den[63]) return U64_MAX;
      for (int i = 0; i < 64 + sh; i++) begin
         b = i < 64 ? num[63-i] : 1'b0;
         if (q[63]) return U64_MAX;
         q = q << 1;
         rem = (rem << 1) | b;
         if (rem >= den) begin
            rem = rem - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic turn_result_type predict_turn(
         logic signed [COORD_WIDTH-1:0] ax, logic signed [COORD_WIDTH-1:0] ay,
         logic signed [COORD_WIDTH-1:0] bx, logic signed [COORD_WIDTH-1:0] by,
         logic signed [COORD_WIDTH-1:0] cx, logic signed [COORD_WIDTH-1:0] cy,
         logic [LEN_WIDTH-1:0] lab, logic [LEN_WIDTH-1:0] lbc,
         logic [CURV_WIDTH-1:0] limit);
      turn_result_type res;
      longint ux, uy, vx, vy, d, x;
      longint unsigned lmin, xm, dm, r, c2, s2, cq, w, k;
      logic straight;
      lmin = lab < lbc ? lab : lbc;
      ux = longint'(bx) - longint'(ax);
      uy = longint'(by) - longint'(ay);
      vx = longint'(bx) - longint'(cx);
      vy = longint'(by) - longint'(cy);
      shrink(ux, uy);
      shrink(vx, vy);
      d = ux * vx + uy * vy;
      x = ux * vy - uy * vx;
      shrink(d, x);
      xm = mag(x);
      straight = (d == 0 && x == 0) ||
                 (d > 0 && (xm << 32) < 64'(TAN_MILLI_Q32) * longint'(d));
      if (straight || lmin == 0) begin
         k = CURV_WIDTH'('1);
      end else begin
         dm = mag(d);
         r = root_floor(dm * dm + xm * xm);
         if (d >= 0) begin
            c2 = quot_shift(r + dm, C2_SHIFT, 2 * r);
            s2 = quot_shift(xm * xm, C2_SHIFT, 2 * r * (r + dm));
         end else begin
            c2 = quot_shift(xm * xm, C2_SHIFT, 2 * r * (r + dm));
            s2 = quot_shift(r + dm, C2_SHIFT, 2 * r);
         end
         if (s2 == 0) begin
            k = CURV_WIDTH'('1);
         end else begin
            cq = root_floor(c2);
            w = quot_shift(cq, W_SHIFT, s2);
            k = quot_shift(w, 0, 3 * lmin);
            if (k > 64'hFFFF_FFFF) k = 64'hFFFF_FFFF;
         end
      end
      res.curv_value = k[CURV_WIDTH-1:0];
      res.near_straight = straight;
      res.feasible = k < longint'(limit);
      return res;
   endfunction

   always @(posedge clock) begin
      turn_result_type exp_res;
      if (reset) begin
         curv_queue.delete();
         curv_limit <= MAX_CURV_RESET;
         pending <= 0;
         fail_count <= 0;
         checked <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            checked <= checked + 1;
            if (curv_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: response with nothing outstanding: curv %h ns %b f %b",
                           $time, rsp_mon.curv_value, rsp_mon.near_straight,
                           rsp_mon.feasible);
               fail_count <= fail_count + 1;
            end else begin
               exp_res = curv_queue.pop_front();
               if (rsp_mon.curv_value !== exp_res.curv_value ||
                   rsp_mon.near_straight !== exp_res.near_straight ||
                   rsp_mon.feasible !== exp_res.feasible) begin
                  if (fail_count < 10)
                     $display("%0t: mismatch: exp curv %h ns %b f %b, got curv %h ns %b f %b",
                              $time, exp_res.curv_value, exp_res.near_straight,
                              exp_res.feasible, rsp_mon.curv_value,
                              rsp_mon.near_straight, rsp_mon.feasible);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            curv_queue.insert(curv_queue.size(),
                              predict_turn(req_mon.a_x, req_mon.a_y, req_mon.b_x,
                                           req_mon.b_y, req_mon.c_x, req_mon.c_y,
                                           req_mon.len_ab, req_mon.len_bc,
                                           curv_limit));
         if (csr_wr_en) curv_limit <= csr_wr_data;
         pending <= curv_queue.size();
      end
   end
endmodule
`default_nettype wire

// File: tb/tb.sv
// Testbench top for the turn curvature check: stimulus, clock, reset and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import tcc_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_WAIT  = 300;

   typedef struct {
      logic signed [COORD_WIDTH-1:0] ax, ay, bx, by, cx, cy;
      logic [LEN_WIDTH-1:0]          lab, lbc;
   } turn_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CURV_WIDTH-1:0] csr_wr_data = '0;
   int unsigned fail_count, pending, checked;
   int unsigned cycles = 0;
   int unsigned sent = 0;
   int unsigned limits_used = 0;
   logic quiet_rsp = 1'b0;
   turn_item_type directed[$];

   tcc_req_if req_ch ();
   tcc_rsp_if rsp_ch ();

   turn_curvature_check i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tcc_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int gap_len();
      if ($urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // random receiver stalls, with stretches of none
   initial begin
      int n;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= 1'b1;
         n = $urandom_range(1, 30);
         repeat (n) @(posedge clock);
         n = quiet_rsp ? 0 : gap_len();
         if (n > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n - 1) @(posedge clock);
         end
      end
   end

   task automatic send_turn(turn_item_type it, bit idle_ok);
      int g;
      req_ch.a_x <= it.ax;
      req_ch.a_y <= it.ay;
      req_ch.b_x <= it.bx;
      req_ch.b_y <= it.by;
      req_ch.c_x <= it.cx;
      req_ch.c_y <= it.cy;
      req_ch.len_ab <= it.lab;
      req_ch.len_bc <= it.lbc;
      req_ch.valid <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
      g = idle_ok ? gap_len() : 0;
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_limit(logic [CURV_WIDTH-1:0] v);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limits_used++;
   endtask

   function automatic void add_turn(int ax, int ay, int bx, int by,
                                    int cx, int cy, int lab, int lbc);
      turn_item_type it;
      it.ax = ax; it.ay = ay; it.bx = bx; it.by = by; it.cx = cx; it.cy = cy;
      it.lab = lab; it.lbc = lbc;
      directed.insert(directed.size(), it);
   endfunction

   function automatic int small_off(int span);
      return $signed($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic turn_item_type random_turn();
      turn_item_type it;
      int sel, dx, dy;
      sel = $urandom_range(0, 9);
      it.ax = $urandom; it.ay = $urandom; it.bx = $urandom;
      it.by = $urandom; it.cx = $urandom; it.cy = $urandom;
      it.lab = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h0040_0000);
      it.lbc = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 32'h0040_0000);
      if (sel >= 2 && sel <= 5) begin
         it.bx = small_off(1 << 24);
         it.by = small_off(1 << 24);
         it.ax = it.bx + small_off(1 << 20);
         it.ay = it.by + small_off(1 << 20);
         it.cx = it.bx + small_off(1 << 20);
         it.cy = it.by + small_off(1 << 20);
      end else if (sel == 6) begin
         dx = small_off(1 << 18);
         dy = small_off(1 << 18);
         it.bx = small_off(1 << 24);
         it.by = small_off(1 << 24);
         it.ax = it.bx - dx;
         it.ay = it.by - dy;
         it.cx = it.bx + dx * $urandom_range(1, 4) + small_off(4);
         it.cy = it.by + dy * $urandom_range(1, 4) + small_off(4);
      end else if (sel == 7) begin
         dx = small_off(1 << 18);
         dy = small_off(1 << 18);
         it.bx = small_off(1 << 24);
         it.by = small_off(1 << 24);
         it.ax = it.bx + dx;
         it.ay = it.by + dy;
         it.cx = it.bx + dx * $urandom_range(1, 4) + small_off(1);
         it.cy = it.by + dy * $urandom_range(1, 4) + small_off(1);
      end else if (sel == 8) begin
         it.lab = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
         it.lbc = $urandom_range(0, 1) ? 32'd0 : $urandom;
      end else if (sel == 9) begin
         it.ax = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         it.cy = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         it.bx = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      end
      return it;
   endfunction

   localparam int ONE  = 65536;
   localparam int PMAX = 32'h7FFF_FFFF;
   localparam int PMIN = 32'h8000_0000;
   localparam int LMAX = 32'hFFFF_FFFF;

   initial begin
      logic [CURV_WIDTH-1:0] limits[6];
      req_ch.valid = 1'b0;
      req_ch.a_x = '0; req_ch.a_y = '0; req_ch.b_x = '0; req_ch.b_y = '0;
      req_ch.c_x = '0; req_ch.c_y = '0; req_ch.len_ab = '0; req_ch.len_bc = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_turn(0, 0, ONE, 0, 2 * ONE, ONE, ONE, ONE);
      add_turn(0, 0, ONE, 0, ONE, ONE, ONE, 2 * ONE);
      add_turn(0, 0, ONE, 0, 2 * ONE, 0, ONE, ONE);
      add_turn(0, 0, ONE, 0, 0, 0, ONE, ONE);
      add_turn(0, 0, ONE, 0, 3 * ONE, 0, ONE, ONE);
      add_turn(0, 0, 0, 0, ONE, ONE, ONE, ONE);
      add_turn(5, 5, 5, 5, 5, 5, ONE, ONE);
      add_turn(0, 0, ONE, 0, 2 * ONE, ONE, 0, ONE);
      add_turn(0, 0, ONE, 0, 2 * ONE, 0, ONE, 0);
      add_turn(0, 0, 1000000, 0, 2000000, 1000, ONE, ONE);
      add_turn(0, 0, 1000000, 0, 2000000, 999, ONE, ONE);
      add_turn(0, 0, 1000000, 0, 2000000, 1001, ONE, ONE);
      add_turn(PMIN, PMIN, PMAX, PMAX, PMIN, PMAX, LMAX, LMAX);
      add_turn(PMAX, PMIN, PMIN, PMAX, PMAX, PMAX, LMAX, 1);
      add_turn(PMAX, PMAX, PMIN, PMIN, PMAX, PMAX, 1, 1);
      add_turn(0, 0, ONE, 0, 2 * ONE, 1, 1, 1);
      add_turn(0, 0, ONE, 0, 2 * ONE, 1, LMAX, LMAX);
      add_turn(0, 0, 0, ONE, ONE, ONE, ONE, ONE);
      add_turn(0, 0, 0, ONE, 1, 0, ONE, ONE);
      add_turn(-ONE, -ONE, 0, 0, ONE, -ONE, 3 * ONE, 2 * ONE);
      foreach (directed[i]) send_turn(directed[i], 1'b1);

      limits = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd65536 * 4, $urandom, 32'd65536};
      foreach (limits[p]) begin
         write_limit(limits[p]);
         quiet_rsp = (p == 2);
         for (int i = 0; i < 215; i++) begin
            if (i == 100) wait_drained();
            send_turn(random_turn(), p != 2);
         end
      end
      write_limit(32'd0);
      foreach (directed[i]) send_turn(directed[i], 1'b0);

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Sent %0d request transactions, %0d responses checked,", sent, checked);
      $display("over %0d curvature limits including zero and all ones.", limits_used);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
src/tcc_pkg.sv
src/tcc_if.sv
src/tcc_isqrt.sv
src/tcc_div.sv
src/turn_curvature_check.sv
tb/tcc_checker.sv
tb/tb.sv
